// ===== rtl/cal_pkg.sv =====
`default_nettype none

package cal_pkg;

    localparam int DEFAULT_CAPACITY = 32;

    localparam int ACTION_W    = 2;
    localparam int VALUE_W     = 32;
    localparam int INDEX_W     = 5;
    localparam int STATUS_W    = 3;
    localparam int COUNT_OUT_W = 6;

    localparam int IN_FIELDS_W  = ACTION_W + VALUE_W + INDEX_W;
    localparam int IN_TDATA_W   = ((IN_FIELDS_W + 7) / 8) * 8;
    localparam int OUT_FIELDS_W = STATUS_W + VALUE_W + COUNT_OUT_W;
    localparam int OUT_TDATA_W  = ((OUT_FIELDS_W + 7) / 8) * 8;
    localparam int OUT_PAD_W    = OUT_TDATA_W - OUT_FIELDS_W;

    typedef enum logic [ACTION_W-1:0] {
        ACT_INSERT = 2'd0,
        ACT_REMOVE = 2'd1,
        ACT_CLEAR  = 2'd2,
        ACT_READ   = 2'd3
    } action_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK        = 3'd0,
        ST_FULL      = 3'd1,
        ST_EMPTY     = 3'd2,
        ST_NOT_FOUND = 3'd3,
        ST_RANGE     = 3'd4
    } status_t;

    typedef struct packed {
        logic    accept;
        logic    append;
        logic    clear_all;
        logic    rd_index;
        logic    rd_first;
        logic    rd_next;
        logic    start_shift;
        logic    shift;
        logic    dec_count;
        logic    set_status;
        logic    set_rdata;
        logic    emit;
        status_t status;
    } cal_cmd_t;

    typedef struct packed {
        action_t action;
        logic    full;
        logic    empty;
        logic    index_ok;
        logic    match;
        logic    scan_last;
        logic    shift_last;
        logic    out_free;
    } cal_flags_t;

endpackage

`default_nettype wire

// ===== rtl/compacting_array_list_unit.sv =====
// Insert, clear and each operation refused without a search go from acceptance straight to the
// result state; a read first waits on the registered read port of the entry memory.
// A remove, hit or miss, searches with one read per cycle up to the hit, then shifts the later
// entries down with one read and write per cycle.
// One item at a time: s_tready stays low until the result is loaded into the output register.
// Reset clears the entry count and the output valid; entry contents stay undefined.
`default_nettype none

module compacting_array_list_unit
    import cal_pkg::*;
#(
    parameter int CAPACITY = DEFAULT_CAPACITY
)
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   s_tvalid,
    output logic                        s_tready,
    // action [1:0], value [33:2], index [38:34]
    input  wire logic [IN_TDATA_W-1:0]  s_tdata,
    output logic                        m_tvalid,
    input  wire logic                   m_tready,
    // status [2:0], read_value [34:3], entry_count [40:35]
    output logic [OUT_TDATA_W-1:0]      m_tdata
);

    cal_cmd_t                cmd;
    cal_flags_t              flags;
    action_t                 in_action;
    logic [VALUE_W-1:0]      in_value;
    logic [INDEX_W-1:0]      in_index;
    logic [STATUS_W-1:0]     out_status;
    logic [VALUE_W-1:0]      out_value;
    logic [COUNT_OUT_W-1:0]  out_count;

    assign in_action = action_t'(s_tdata[ACTION_W-1:0]);
    assign in_value  = s_tdata[ACTION_W +: VALUE_W];
    assign in_index  = s_tdata[ACTION_W+VALUE_W +: INDEX_W];

    cal_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .flags    (flags),
        .cmd      (cmd)
    );

    cal_dp #(
        .CAPACITY (CAPACITY)
    ) u_dp
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_action  (in_action),
        .in_value   (in_value),
        .in_index   (in_index),
        .cmd        (cmd),
        .flags      (flags),
        .m_tready   (m_tready),
        .out_valid  (m_tvalid),
        .out_status (out_status),
        .out_value  (out_value),
        .out_count  (out_count)
    );

    assign m_tdata = {{OUT_PAD_W{1'b0}}, out_count, out_value, out_status};

endmodule

`default_nettype wire

// ===== rtl/cal_ctrl.sv =====
`default_nettype none

module cal_ctrl
    import cal_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       s_tvalid,
    output logic            s_tready,
    input  wire cal_flags_t flags,
    output cal_cmd_t        cmd
);

    typedef enum logic [4:0] {
        S_IDLE    = 5'b00001,
        S_RD_WAIT = 5'b00010,
        S_SCAN    = 5'b00100,
        S_SHIFT   = 5'b01000,
        S_DONE    = 5'b10000
    } state_t;

    state_t state_reg;
    state_t state_next;

    assign s_tready = (state_reg == S_IDLE);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        cmd        = '0;
        cmd.status = ST_OK;
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (s_tvalid)
                begin
                    cmd.accept = 1'b1;
                    case (flags.action)
                        ACT_INSERT:
                        begin
                            cmd.set_status = 1'b1;
                            if (flags.full)
                            begin
                                cmd.status = ST_FULL;
                            end
                            else
                            begin
                                cmd.append = 1'b1;
                            end
                            state_next = S_DONE;
                        end
                        ACT_REMOVE:
                        begin
                            if (flags.empty)
                            begin
                                cmd.set_status = 1'b1;
                                cmd.status     = ST_EMPTY;
                                state_next     = S_DONE;
                            end
                            else
                            begin
                                cmd.rd_first = 1'b1;
                                state_next   = S_SCAN;
                            end
                        end
                        ACT_CLEAR:
                        begin
                            cmd.set_status = 1'b1;
                            if (flags.empty)
                            begin
                                cmd.status = ST_EMPTY;
                            end
                            else
                            begin
                                cmd.clear_all = 1'b1;
                            end
                            state_next = S_DONE;
                        end
                        ACT_READ:
                        begin
                            if (flags.index_ok)
                            begin
                                cmd.rd_index = 1'b1;
                                state_next   = S_RD_WAIT;
                            end
                            else
                            begin
                                cmd.set_status = 1'b1;
                                cmd.status     = ST_RANGE;
                                state_next     = S_DONE;
                            end
                        end
                        default:
                        begin
                            state_next = S_IDLE;
                        end
                    endcase
                end
            end
            S_RD_WAIT:
            begin
                cmd.set_status = 1'b1;
                cmd.set_rdata  = 1'b1;
                state_next     = S_DONE;
            end
            S_SCAN:
            begin
                if (flags.match)
                begin
                    if (flags.scan_last)
                    begin
                        cmd.dec_count  = 1'b1;
                        cmd.set_status = 1'b1;
                        state_next     = S_DONE;
                    end
                    else
                    begin
                        cmd.start_shift = 1'b1;
                        state_next      = S_SHIFT;
                    end
                end
                else if (flags.scan_last)
                begin
                    cmd.set_status = 1'b1;
                    cmd.status     = ST_NOT_FOUND;
                    state_next     = S_DONE;
                end
                else
                begin
                    cmd.rd_next = 1'b1;
                end
            end
            S_SHIFT:
            begin
                cmd.shift = 1'b1;
                if (flags.shift_last)
                begin
                    cmd.dec_count  = 1'b1;
                    cmd.set_status = 1'b1;
                    state_next     = S_DONE;
                end
            end
            S_DONE:
            begin
                if (flags.out_free)
                begin
                    cmd.emit   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

// ===== rtl/cal_dp.sv =====
`default_nettype none

module cal_dp
    import cal_pkg::*;
#(
    parameter int CAPACITY = DEFAULT_CAPACITY
)
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire action_t                in_action,
    input  wire logic [VALUE_W-1:0]     in_value,
    input  wire logic [INDEX_W-1:0]     in_index,
    input  wire cal_cmd_t               cmd,
    output cal_flags_t                  flags,
    input  wire logic                   m_tready,
    output logic                        out_valid,
    output logic [STATUS_W-1:0]         out_status,
    output logic [VALUE_W-1:0]          out_value,
    output logic [COUNT_OUT_W-1:0]      out_count
);

    localparam int AW = $clog2(CAPACITY);
    localparam int CW = $clog2(CAPACITY + 1);
    localparam logic [CW-1:0] CAP_C = CW'(CAPACITY);

    logic [VALUE_W-1:0] mem [CAPACITY];

    logic [CW-1:0]       count_reg;
    logic [CW-1:0]       count_next;
    logic [AW-1:0]       ptr_reg;
    logic [AW-1:0]       ptr_next;
    logic [VALUE_W-1:0]  value_reg;
    logic [VALUE_W-1:0]  rd_data_reg;
    status_t             res_status_reg;
    logic [VALUE_W-1:0]  res_value_reg;
    logic                out_valid_reg;
    logic [STATUS_W-1:0] out_status_reg;
    logic [VALUE_W-1:0]  out_value_reg;
    logic [COUNT_OUT_W-1:0] out_count_reg;

    logic                we;
    logic [AW-1:0]       waddr;
    logic [VALUE_W-1:0]  wdata;
    logic                re;
    logic [AW-1:0]       raddr;

    logic [CW+INDEX_W-1:0]    idx_c;
    logic [CW+INDEX_W-1:0]    cnt_i;
    logic [AW+INDEX_W-1:0]    idx_a;
    logic [AW+CW-1:0]         cnt_a;
    logic [AW+CW-1:0]         ptr_c;
    logic [CW+COUNT_OUT_W-1:0] cnt_o;
    logic                     out_free;

    assign idx_c = {{CW{1'b0}}, in_index};
    assign cnt_i = {{INDEX_W{1'b0}}, count_reg};
    assign idx_a = {{AW{1'b0}}, in_index};
    assign cnt_a = {{AW{1'b0}}, count_reg};
    assign ptr_c = {{CW{1'b0}}, ptr_reg};
    assign cnt_o = {{COUNT_OUT_W{1'b0}}, count_reg};

    assign out_free = !out_valid_reg || m_tready;

    assign flags.action     = in_action;
    assign flags.full       = (count_reg >= CAP_C);
    assign flags.empty      = (count_reg == '0);
    assign flags.index_ok   = (idx_c < cnt_i);
    assign flags.match      = (rd_data_reg == value_reg);
    assign flags.scan_last  = ((ptr_c + (AW+CW)'(1)) >= cnt_a);
    assign flags.shift_last = ((ptr_c + (AW+CW)'(2)) >= cnt_a);
    assign flags.out_free   = out_free;

    always_comb
    begin
        we    = 1'b0;
        waddr = ptr_reg;
        wdata = rd_data_reg;
        if (cmd.append)
        begin
            we    = 1'b1;
            waddr = cnt_a[AW-1:0];
            wdata = in_value;
        end
        else if (cmd.shift)
        begin
            we = 1'b1;
        end
    end

    always_comb
    begin
        re    = 1'b1;
        raddr = ptr_reg + AW'(1);
        if (cmd.rd_index)
        begin
            raddr = idx_a[AW-1:0];
        end
        else if (cmd.rd_first)
        begin
            raddr = '0;
        end
        else if (cmd.shift)
        begin
            raddr = ptr_reg + AW'(2);
        end
        else if (!(cmd.rd_next || cmd.start_shift))
        begin
            re = 1'b0;
        end
    end

    always_comb
    begin
        count_next = count_reg;
        if (cmd.append)
        begin
            count_next = count_reg + CW'(1);
        end
        else if (cmd.clear_all)
        begin
            count_next = '0;
        end
        else if (cmd.dec_count)
        begin
            count_next = count_reg - CW'(1);
        end
    end

    always_comb
    begin
        ptr_next = ptr_reg;
        if (cmd.rd_first)
        begin
            ptr_next = '0;
        end
        else if (cmd.rd_next || cmd.shift)
        begin
            ptr_next = ptr_reg + AW'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rd_data_reg <= mem[raddr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            count_reg <= count_next;
            if (cmd.emit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        ptr_reg <= ptr_next;
        if (cmd.accept)
        begin
            value_reg <= in_value;
        end
        if (cmd.set_status)
        begin
            res_status_reg <= cmd.status;
            res_value_reg  <= cmd.set_rdata ? rd_data_reg : '0;
        end
        if (cmd.emit)
        begin
            out_status_reg <= res_status_reg;
            out_value_reg  <= res_value_reg;
            out_count_reg  <= cnt_o[COUNT_OUT_W-1:0];
        end
    end

    assign out_valid  = out_valid_reg;
    assign out_status = out_status_reg;
    assign out_value  = out_value_reg;
    assign out_count  = out_count_reg;

    assert property (@(posedge clk) disable iff (!rst_n) count_reg <= CAP_C)
        else $error("Entry count exceeds capacity.");

    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.append |=> count_reg == $past(count_reg) + CW'(1))
        else $error("Insert did not advance the entry count.");

    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.dec_count |-> count_reg != '0)
        else $error("Remove taken from an empty list.");

    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.emit |-> out_free)
        else $error("Result overwrote a beat not yet taken.");

endmodule

`default_nettype wire

// ===== tb/sv/compacting_array_list_checker.sv =====
`timescale 1ns / 100ps

module compacting_array_list_checker
    import cal_pkg::*;
#(
    parameter int CAPACITY = DEFAULT_CAPACITY
)
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   s_tvalid,
    input  wire logic                   s_tready,
    // action [1:0], value [33:2], index [38:34]
    input  wire logic [IN_TDATA_W-1:0]  s_tdata,
    input  wire logic                   m_tvalid,
    input  wire logic                   m_tready,
    // status [2:0], read_value [34:3], entry_count [40:35]
    input  wire logic [OUT_TDATA_W-1:0] m_tdata,
    output int                          fail_count,
    output int                          pending
);

    typedef struct packed {
        status_t                  status;
        logic [VALUE_W-1:0]       read_value;
        logic [COUNT_OUT_W-1:0]   entry_count;
    } list_result_t;

    logic [VALUE_W-1:0] held_words [CAPACITY];
    int unsigned        held_count;
    list_result_t       awaited [$];

    function automatic list_result_t apply_op(input action_t act,
                                              input logic [VALUE_W-1:0] word,
                                              input logic [INDEX_W-1:0] pos);
        list_result_t res;
        int           hit;
        res.status     = ST_OK;
        res.read_value = '0;
        hit            = -1;
        case (act)
            ACT_INSERT:
            begin
                if (held_count >= CAPACITY)
                    res.status = ST_FULL;
                else
                begin
                    held_words[held_count] = word;
                    held_count++;
                end
            end
            ACT_REMOVE:
            begin
                if (held_count == 0)
                    res.status = ST_EMPTY;
                else
                begin
                    for (int i = 0; i < held_count; i++)
                    begin
                        if (hit < 0 && held_words[i] == word)
                            hit = i;
                    end
                    if (hit < 0)
                        res.status = ST_NOT_FOUND;
                    else
                    begin
                        for (int i = hit; i + 1 < held_count; i++)
                            held_words[i] = held_words[i + 1];
                        held_count--;
                    end
                end
            end
            ACT_CLEAR:
            begin
                if (held_count == 0)
                    res.status = ST_EMPTY;
                else
                    held_count = 0;
            end
            default:
            begin
                if (pos >= held_count || pos >= CAPACITY)
                    res.status = ST_RANGE;
                else
                    res.read_value = held_words[pos];
            end
        endcase
        res.entry_count = COUNT_OUT_W'(held_count);
        return res;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        list_result_t want;
        list_result_t got;
        if (!rst_n)
        begin
            held_count = 0;
            awaited.delete();
            fail_count = 0;
            pending    = 0;
        end
        else
        begin
            if (m_tvalid && m_tready)
            begin
                got.status      = status_t'(m_tdata[STATUS_W-1:0]);
                got.read_value  = m_tdata[STATUS_W +: VALUE_W];
                got.entry_count = m_tdata[STATUS_W + VALUE_W +: COUNT_OUT_W];
                if (awaited.size() == 0)
                begin
                    fail_count++;
                    $display("%0t: unexpected result beat, actual %h", $time, m_tdata);
                end
                else
                begin
                    want = awaited.pop_front();
                    if (got.status !== want.status)
                    begin
                        fail_count++;
                        $display("%0t: status expected %0d actual %0d",
                                 $time, want.status, got.status);
                    end
                    if (got.read_value !== want.read_value)
                    begin
                        fail_count++;
                        $display("%0t: read_value expected %h actual %h",
                                 $time, want.read_value, got.read_value);
                    end
                    if (got.entry_count !== want.entry_count)
                    begin
                        fail_count++;
                        $display("%0t: entry_count expected %0d actual %0d",
                                 $time, want.entry_count, got.entry_count);
                    end
                end
            end
            if (s_tvalid && s_tready)
                awaited.push_back(apply_op(action_t'(s_tdata[ACTION_W-1:0]),
                                           s_tdata[ACTION_W +: VALUE_W],
                                           s_tdata[ACTION_W + VALUE_W +: INDEX_W]));
            pending = awaited.size();
        end
    end

endmodule

// ===== tb/sv/compacting_array_list_unit_tb.sv =====
`timescale 1ns / 100ps

module compacting_array_list_unit_tb;
    import cal_pkg::*;

    localparam int CAPACITY    = DEFAULT_CAPACITY;
    localparam int CYCLE_LIMIT = 1000000;
    localparam int LONG_HOLD   = 300;
    localparam int PHASES      = 34;
    localparam int PHASE_ITEMS = 50;

    typedef enum int {PH_FILL, PH_DRAIN, PH_MIXED} phase_kind_t;

    logic                   clk;
    logic                   rst_n;
    logic                   s_tvalid;
    logic                   s_tready;
    logic [IN_TDATA_W-1:0]  s_tdata;
    logic                   m_tvalid;
    logic                   m_tready;
    logic [OUT_TDATA_W-1:0] m_tdata;
    int                     fail_count;
    int                     pending;
    int                     cycle_count;
    bit                     quiet_run;
    bit                     long_hold_req;
    logic [VALUE_W-1:0]     word_pool [8];

    compacting_array_list_unit #(.CAPACITY(CAPACITY)) dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    compacting_array_list_checker #(.CAPACITY(CAPACITY)) checker_i (
        .clk        (clk),
        .rst_n      (rst_n),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .fail_count (fail_count),
        .pending    (pending)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("Some tests failed");
            $finish;
        end
    end

    task automatic offer_op(input action_t act, input logic [VALUE_W-1:0] word,
                            input logic [INDEX_W-1:0] pos);
        int gap;
        gap = quiet_run ? 0 : $urandom_range(0, 15);
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {{(IN_TDATA_W - IN_FIELDS_W){1'b0}}, pos, word, act};
        do
            @(posedge clk);
        while (!s_tready);
        @(negedge clk);
    endtask

    task automatic run_phase(input phase_kind_t kind);
        int                 roll;
        action_t            act;
        logic [VALUE_W-1:0] word;
        for (int i = 0; i < 8; i++)
            word_pool[i] = $urandom();
        word_pool[0] = (kind == PH_FILL) ? '0 : '1;
        for (int n = 0; n < PHASE_ITEMS; n++)
        begin
            roll = $urandom_range(0, 99);
            case (kind)
                PH_FILL:
                    act = roll < 70 ? ACT_INSERT : roll < 85 ? ACT_READ :
                          roll < 99 ? ACT_REMOVE : ACT_CLEAR;
                PH_DRAIN:
                    act = roll < 15 ? ACT_INSERT : roll < 30 ? ACT_READ :
                          roll < 98 ? ACT_REMOVE : ACT_CLEAR;
                default:
                    act = roll < 40 ? ACT_INSERT : roll < 70 ? ACT_READ :
                          roll < 96 ? ACT_REMOVE : ACT_CLEAR;
            endcase
            word = ($urandom_range(0, 3) == 0) ? $urandom() : word_pool[$urandom_range(0, 7)];
            offer_op(act, word, INDEX_W'($urandom_range(0, 31)));
        end
    endtask

    task automatic wait_drained();
        while (pending != 0)
            @(negedge clk);
    endtask

    initial
    begin
        int stall;
        m_tready = 1'b0;
        wait (rst_n === 1'b1);
        @(negedge clk);
        forever
        begin
            stall = quiet_run ? 0 : $urandom_range(0, 15);
            if (stall > 0)
            begin
                m_tready <= 1'b0;
                repeat (stall) @(negedge clk);
            end
            if (long_hold_req)
            begin
                long_hold_req = 1'b0;
                m_tready <= 1'b0;
                repeat (LONG_HOLD) @(negedge clk);
            end
            m_tready <= 1'b1;
            do
                @(posedge clk);
            while (!m_tvalid);
            @(negedge clk);
        end
    end

    initial
    begin
        phase_kind_t kind;
        rst_n         = 1'b0;
        s_tvalid      = 1'b0;
        s_tdata       = '0;
        cycle_count   = 0;
        quiet_run     = 1'b0;
        long_hold_req = 1'b0;
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Rejections on an empty list, then duplicates, head, middle and tail removal.
        offer_op(ACT_READ,   32'h0000_0000, 5'd0);
        offer_op(ACT_REMOVE, 32'hFFFF_FFFF, 5'd0);
        offer_op(ACT_CLEAR,  32'h0000_0000, 5'd0);
        offer_op(ACT_INSERT, 32'h0000_0000, 5'd0);
        offer_op(ACT_INSERT, 32'hFFFF_FFFF, 5'd0);
        offer_op(ACT_INSERT, 32'h8000_0001, 5'd0);
        offer_op(ACT_INSERT, 32'hFFFF_FFFF, 5'd0);
        offer_op(ACT_INSERT, 32'h7FFF_FFFE, 5'd0);
        offer_op(ACT_READ,   32'h0000_0000, 5'd0);
        offer_op(ACT_READ,   32'h0000_0000, 5'd4);
        offer_op(ACT_READ,   32'h0000_0000, 5'd5);
        offer_op(ACT_READ,   32'h0000_0000, 5'd31);
        offer_op(ACT_REMOVE, 32'hFFFF_FFFF, 5'd0);
        offer_op(ACT_READ,   32'h0000_0000, 5'd1);
        offer_op(ACT_READ,   32'h0000_0000, 5'd2);
        offer_op(ACT_REMOVE, 32'h1234_5678, 5'd0);
        offer_op(ACT_REMOVE, 32'h0000_0000, 5'd0);
        offer_op(ACT_REMOVE, 32'h7FFF_FFFE, 5'd0);
        offer_op(ACT_READ,   32'h0000_0000, 5'd0);
        offer_op(ACT_INSERT, 32'hA5A5_5A5A, 5'd31);
        offer_op(ACT_READ,   32'hFFFF_FFFF, 5'd0);
        offer_op(ACT_CLEAR,  32'hFFFF_FFFF, 5'd31);
        offer_op(ACT_READ,   32'h0000_0000, 5'd0);

        for (int p = 0; p < PHASES; p++)
        begin
            if (p == 12 || p == 25)
            begin
                s_tvalid <= 1'b0;
                wait_drained();
            end
            if (p == 7 || p == 20)
                long_hold_req = 1'b1;
            quiet_run = (p % 5 == 2);
            kind = (p == 0) ? PH_FILL : phase_kind_t'($urandom_range(0, 2));
            run_phase(kind);
        end
        s_tvalid <= 1'b0;

        wait_drained();
        repeat (40) @(negedge clk);
        if (fail_count == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
